// File: hdl/femt_pkg.sv
package femt_pkg;

    localparam int TOKEN_W = 160;
    localparam int COUNT_W = 9;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_CONSUME = 1'b1;

    typedef logic [TOKEN_W-1:0] token_t;

    typedef struct packed {
        logic ins;
        logic full;
        logic cmp;
        logic del;
    } cell_ctrl_t;

endpackage

// File: hdl/femt_cell.sv
module femt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  femt_pkg::cell_ctrl_t ctrl,
    input  femt_pkg::token_t    token,
    input  logic                take,
    input  logic                prev_valid,
    input  logic                next_valid,
    input  femt_pkg::token_t    next_data,
    output femt_pkg::token_t    data,
    output logic                valid,
    output logic                match
);

    femt_pkg::token_t data_reg;
    femt_pkg::token_t data_next;
    logic             valid_reg;
    logic             valid_next;
    logic             match_reg;
    logic             match_next;
    logic             shift;
    logic             fill;

    always_comb
    begin
        shift      = (ctrl.ins && ctrl.full) || (ctrl.del && take);
        fill       = ctrl.ins && !ctrl.full && !valid_reg && prev_valid;
        data_next  = data_reg;
        valid_next = valid_reg;
        if (shift)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (fill)
        begin
            data_next  = token;
            valid_next = 1'b1;
        end
        match_next = ctrl.cmp ? (valid_reg && (data_reg == token)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

// File: hdl/femt_prefix_or.sv
module femt_prefix_or
#(
    parameter int WIDTH = 256
)
(
    input  logic [WIDTH-1:0] bits,
    output logic [WIDTH-1:0] incl
);

    localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] lvl [LEVELS+1];

    assign lvl[0] = bits;

    for (genvar k = 0; k < LEVELS; k++)
    begin : g_level
        for (genvar i = 0; i < WIDTH; i++)
        begin : g_bit
            if (i >= (1 << k))
            begin : g_or
                assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1 << k)];
            end
            else
            begin : g_pass
                assign lvl[k+1][i] = lvl[k][i];
            end
        end
    end

    assign incl = lvl[LEVELS];

endmodule

// File: hdl/fifo_evicting_match_table_core.sv
// An insert is accepted in IDLE and answered from CMP; a consume is answered from RES.
// The accept/compare/resolve sequencer over the cell row takes a new item only in IDLE,
//   after the last result is registered; a stalled output holds it in CMP or RES.
// In CMP the row compares all cells in parallel; in RES a prefix OR picks the oldest match.
// Reset (rst_n low, asynchronous): all cells invalid, occupancy zero, no result pending.
module fifo_evicting_match_table_core
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [63:0] token_low,
    input  logic [63:0] token_mid,
    input  logic [31:0] token_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        matched,
    output logic        evicted,
    output logic [8:0]  entry_count
);

    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = femt_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 cmd_reg;
    logic                 cmd_next;
    femt_pkg::token_t     token_reg;
    femt_pkg::token_t     token_next;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 matched_reg;
    logic                 matched_next;
    logic                 evicted_reg;
    logic                 evicted_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    femt_pkg::cell_ctrl_t ctrl;
    logic                 out_free;
    logic                 full;

    femt_pkg::token_t     cell_data [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_valid;
    logic [TABLE_DEPTH-1:0] cell_match;
    logic [TABLE_DEPTH-1:0] take;

    assign full     = cell_valid[TABLE_DEPTH-1];
    assign out_free = !out_valid_reg || out_ready;

    femt_prefix_or #(.WIDTH(TABLE_DEPTH)) u_prefix
    (
        .bits (cell_match),
        .incl (take)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic             prev_v;
        logic             next_v;
        femt_pkg::token_t next_d;

        if (g == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_v = cell_valid[g-1];
        end

        if (g == TABLE_DEPTH - 1)
        begin : g_tail
            assign next_v = (cmd_reg == femt_pkg::CMD_INSERT);
            assign next_d = token_reg;
        end
        else
        begin : g_link
            assign next_v = cell_valid[g+1];
            assign next_d = cell_data[g+1];
        end

        femt_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .token      (token_reg),
            .take       (take[g]),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_data  (next_d),
            .data       (cell_data[g]),
            .valid      (cell_valid[g]),
            .match      (cell_match[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        token_next     = token_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        evicted_next   = evicted_reg;
        count_next     = count_reg;
        ctrl           = '0;
        ctrl.full      = full;
        in_ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    token_next = {token_high, token_mid, token_low};
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (cmd_reg == femt_pkg::CMD_INSERT)
                begin
                    if (out_free)
                    begin
                        ctrl.ins       = 1'b1;
                        if (!full)
                        begin
                            occ_next = occ_reg + OCC_W'(1);
                        end
                        out_valid_next = 1'b1;
                        matched_next   = 1'b0;
                        evicted_next   = full;
                        count_next     = CW'(occ_next);
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    ctrl.cmp   = 1'b1;
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    ctrl.del = 1'b1;
                    if (take[TABLE_DEPTH-1])
                    begin
                        occ_next = occ_reg - OCC_W'(1);
                    end
                    out_valid_next = 1'b1;
                    matched_next   = take[TABLE_DEPTH-1];
                    evicted_next   = 1'b0;
                    count_next     = CW'(occ_next);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        token_reg   <= token_next;
        matched_reg <= matched_next;
        evicted_reg <= evicted_next;
        count_reg   <= count_next;
    end

    assign out_valid   = out_valid_reg;
    assign matched     = matched_reg;
    assign evicted     = evicted_reg;
    assign entry_count = count_reg;

endmodule

// File: hdl/femt_checker.sv
module femt_checker
#(
    parameter int DEPTH = 256
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        matched,
    input logic        evicted,
    input logic [8:0]  entry_count
);

    localparam logic [9:0] DEPTH_W = 10'(DEPTH);
    localparam logic       SMALL   = (DEPTH <= 511);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(evicted)
            && $stable(entry_count))
        else $error("result beat changed while stalled");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(matched && evicted))
        else $error("matched and evicted both set");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && SMALL |-> {1'b0, entry_count} <= DEPTH_W)
        else $error("entry count above table depth");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted && SMALL |-> {1'b0, entry_count} == DEPTH_W)
        else $error("eviction reported on a table that is not full");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

endmodule

bind fifo_evicting_match_table_core femt_checker #(.DEPTH(TABLE_DEPTH)) u_femt_checker (.*);
